// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge, muted while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset cycles included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/pac_pkg.sv
// Package: types, register indexes and reset values for the axis PID controller.
package pac_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D         = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ERROR_DEADZONE = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_PULSES     = 3'd7;

    localparam logic [9:0]  RST_SETPOINT       = 10'd160;
    localparam logic [23:0] RST_GAIN_P         = 24'd65536;
    localparam logic [23:0] RST_GAIN_I         = 24'd0;
    localparam logic [23:0] RST_GAIN_D         = 24'd0;
    localparam logic [19:0] RST_INTEGRAL_LIMIT = 20'd65536;
    localparam logic [15:0] RST_OUTPUT_LIMIT   = 16'd1000;
    localparam logic [9:0]  RST_ERROR_DEADZONE = 10'd3;
    localparam logic [15:0] RST_MIN_PULSES     = 16'd2;

    localparam bit INVERT_DIRECTION_DEF = 1'b0;

    typedef struct packed {
        logic [9:0]  setpoint;
        logic [23:0] gain_p;
        logic [23:0] gain_i;
        logic [23:0] gain_d;
        logic [19:0] integral_limit;
        logic [15:0] output_limit;
        logic [9:0]  error_deadzone;
        logic [15:0] min_pulses;
    } t_cfg;

    // Error stage results handed to the integrator stage.
    typedef struct packed {
        logic               restart;
        logic               sign_flip;
        logic               p_small;
        logic signed [10:0] err;
        logic signed [18:0] p;
        logic signed [19:0] d;
    } t_front;

endpackage

// File: rtl/core/pac_front.sv
// Error stage: input register, deadzone, P and D products, previous error tracking.
module pac_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pac_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [9:0]      i_position,
    input  logic            i_restart,
    output logic            o_valid,
    input  logic            i_ready,
    output pac_pkg::t_front o_front
);
    import pac_pkg::*;

    logic               r_s0_v;
    logic [9:0]         r_pos;
    logic               r_rst;
    logic               r_s1_v;
    t_front             r_front;
    logic signed [10:0] r_last_err;

    logic               w_ready1;
    logic               w_ready0;
    logic               w_mv1;
    logic signed [10:0] w_err_raw;
    logic [10:0]        w_err_abs;
    logic signed [10:0] w_err;
    logic signed [10:0] w_prev;
    logic signed [11:0] w_diff;
    logic signed [35:0] w_p_prod;
    logic signed [36:0] w_d_prod;
    logic signed [18:0] w_p;
    logic [18:0]        w_p_abs;
    logic               w_err_pos;
    logic               w_err_neg;
    logic               w_prev_pos;
    logic               w_prev_neg;
    t_front             n_front;

    assign w_ready1 = !r_s1_v || i_ready;
    assign w_ready0 = !r_s0_v || w_ready1;
    assign w_mv1    = r_s0_v && w_ready1;
    assign o_stall  = !w_ready0;
    assign o_valid  = r_s1_v;
    assign o_front  = r_front;

    always_comb begin
        w_err_raw = $signed({1'b0, i_cfg.setpoint}) - $signed({1'b0, r_pos});
        w_err_abs = w_err_raw[10] ? 11'(-w_err_raw) : 11'(w_err_raw);
        w_err     = (w_err_abs < {1'b0, i_cfg.error_deadzone}) ? 11'sd0 : w_err_raw;
        w_prev    = r_rst ? 11'sd0 : r_last_err;
        w_diff    = $signed({w_err[10], w_err} - {w_prev[10], w_prev});
        w_p_prod  = $signed({1'b0, i_cfg.gain_p}) * w_err;
        w_d_prod  = $signed({1'b0, i_cfg.gain_d}) * w_diff;
        w_p       = $signed(w_p_prod[34:16]);
        w_p_abs   = w_p[18] ? 19'(-w_p) : 19'(w_p);

        w_err_pos  = !w_err[10] && (w_err != 11'sd0);
        w_err_neg  = w_err[10];
        w_prev_pos = !w_prev[10] && (w_prev != 11'sd0);
        w_prev_neg = w_prev[10];

        n_front.restart   = r_rst;
        n_front.sign_flip = (w_err_pos && w_prev_neg) || (w_err_neg && w_prev_pos);
        n_front.p_small   = w_p_abs < {3'b0, i_cfg.output_limit};
        n_front.err       = w_err;
        n_front.p         = w_p;
        n_front.d         = $signed(w_d_prod[35:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v     <= 1'b0;
            r_s1_v     <= 1'b0;
            r_last_err <= '0;
        end else begin
            if (w_ready0) begin
                r_s0_v <= i_valid;
            end
            if (w_ready1) begin
                r_s1_v <= r_s0_v;
            end
            if (w_mv1) begin
                r_last_err <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready0 && i_valid) begin
            r_pos <= i_position;
            r_rst <= i_restart;
        end
        if (w_mv1) begin
            r_front <= n_front;
        end
    end

endmodule

// File: rtl/core/pac_back.sv
// Integrator stage: integral update, I product, output clamp with back-calculation, minimum pulse and direction.
module pac_back #(
    parameter bit INVERT_DIRECTION = pac_pkg::INVERT_DIRECTION_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pac_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  pac_pkg::t_front i_front,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [15:0]     o_pulse_count,
    output logic            o_direction
);
    import pac_pkg::*;

    logic               r_out_v;
    logic [15:0]        r_pulse;
    logic               r_dir;
    logic signed [21:0] r_acc;

    logic               w_mv;
    logic signed [21:0] w_acc0;
    logic signed [22:0] w_acc_add;
    logic signed [22:0] w_lim;
    logic signed [22:0] w_nlim;
    logic signed [21:0] w_acc_clamp;
    logic signed [21:0] w_acc_cand;
    logic signed [46:0] w_i_prod;
    logic signed [29:0] w_i;
    logic signed [30:0] w_sum;
    logic signed [30:0] w_olim;
    logic signed [30:0] w_nolim;
    logic               w_pos_sat;
    logic               w_neg_sat;
    logic               w_err_pos;
    logic               w_err_neg;
    logic               w_back;
    logic signed [21:0] w_acc_fin;
    logic signed [16:0] w_sat;
    logic [16:0]        w_mag;
    logic               w_zero;
    logic [15:0]        n_pulse;
    logic               n_dir;

    assign o_ready = !r_out_v || !i_stall;
    assign w_mv    = i_valid && o_ready;
    assign o_valid = r_out_v;
    assign o_pulse_count = r_pulse;
    assign o_direction   = r_dir;

    always_comb begin
        w_acc0    = i_front.restart ? 22'sd0 : r_acc;
        w_acc_add = $signed({w_acc0[21], w_acc0}) + $signed({{12{i_front.err[10]}}, i_front.err});
        w_lim     = $signed({3'b0, i_cfg.integral_limit});
        w_nlim    = -w_lim;
        if (w_acc_add > w_lim) begin
            w_acc_clamp = w_lim[21:0];
        end else if (w_acc_add < w_nlim) begin
            w_acc_clamp = w_nlim[21:0];
        end else begin
            w_acc_clamp = w_acc_add[21:0];
        end

        if (i_front.sign_flip) begin
            w_acc_cand = 22'sd0;
        end else if (i_front.p_small) begin
            w_acc_cand = w_acc_clamp;
        end else begin
            w_acc_cand = w_acc0;
        end

        w_i_prod = $signed({1'b0, i_cfg.gain_i}) * w_acc_cand;
        w_i      = $signed(w_i_prod[45:16]);
        w_sum    = $signed({{12{i_front.p[18]}}, i_front.p})
                 + $signed({w_i[29], w_i})
                 + $signed({{11{i_front.d[19]}}, i_front.d});

        w_olim    = $signed({15'b0, i_cfg.output_limit});
        w_nolim   = -w_olim;
        w_pos_sat = w_sum > w_olim;
        w_neg_sat = w_sum < w_nolim;

        w_err_pos = !i_front.err[10] && (i_front.err != 11'sd0);
        w_err_neg = i_front.err[10];
        w_back    = (w_pos_sat && (w_acc_cand > 22'sd0) && w_err_pos)
                 || (w_neg_sat && (w_acc_cand < 22'sd0) && w_err_neg);
        w_acc_fin = w_back ? (w_acc_cand - $signed({{11{i_front.err[10]}}, i_front.err}))
                           : w_acc_cand;

        if (w_pos_sat) begin
            w_sat = w_olim[16:0];
        end else if (w_neg_sat) begin
            w_sat = w_nolim[16:0];
        end else begin
            w_sat = w_sum[16:0];
        end
        w_mag   = w_sat[16] ? 17'(-w_sat) : 17'(w_sat);
        w_zero  = w_mag[15:0] < i_cfg.min_pulses;
        n_pulse = w_zero ? 16'd0 : w_mag[15:0];
        n_dir   = (!w_zero && w_sat[16]) ^ INVERT_DIRECTION;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_acc   <= '0;
        end else begin
            if (o_ready) begin
                r_out_v <= i_valid;
            end
            if (w_mv) begin
                r_acc <= w_acc_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv) begin
            r_pulse <= n_pulse;
            r_dir   <= n_dir;
        end
    end

endmodule

// File: rtl/core/pid_axis_controller_antiwindup.sv
// Top level: single-axis PID with anti-windup, configuration registers and pipeline.
// An accepted request passes the input, error and result registers; one request per cycle
// unless the output stalls. The integrator loop closes inside the result stage.
// Output stall backs up one stage at a time, so bubbles are filled before input stalls.
// Reset (synchronous, active low) empties the pipeline, clears the integral and the
// previous error, and loads the register defaults.
module pid_axis_controller_antiwindup #(
    parameter bit INVERT_DIRECTION = pac_pkg::INVERT_DIRECTION_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pac_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [pac_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [9:0]                     i_position,
    input  logic                           i_restart,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [15:0]                    o_pulse_count,
    output logic                           o_direction
);
    import pac_pkg::*;

    t_cfg   r_cfg;
    t_front w_front;
    logic   w_front_v;
    logic   w_back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint       <= RST_SETPOINT;
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.integral_limit <= RST_INTEGRAL_LIMIT;
            r_cfg.output_limit   <= RST_OUTPUT_LIMIT;
            r_cfg.error_deadzone <= RST_ERROR_DEADZONE;
            r_cfg.min_pulses     <= RST_MIN_PULSES;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_SETPOINT:       r_cfg.setpoint       <= i_cfg_wdata[9:0];
                REG_GAIN_P:         r_cfg.gain_p         <= i_cfg_wdata[23:0];
                REG_GAIN_I:         r_cfg.gain_i         <= i_cfg_wdata[23:0];
                REG_GAIN_D:         r_cfg.gain_d         <= i_cfg_wdata[23:0];
                REG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_wdata[19:0];
                REG_OUTPUT_LIMIT:   r_cfg.output_limit   <= i_cfg_wdata[15:0];
                REG_ERROR_DEADZONE: r_cfg.error_deadzone <= i_cfg_wdata[9:0];
                REG_MIN_PULSES:     r_cfg.min_pulses     <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    pac_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_position (i_position),
        .i_restart  (i_restart),
        .o_valid    (w_front_v),
        .i_ready    (w_back_ready),
        .o_front    (w_front)
    );

    pac_back #(
        .INVERT_DIRECTION (INVERT_DIRECTION)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (w_front_v),
        .o_ready       (w_back_ready),
        .i_front       (w_front),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pulse_count (o_pulse_count),
        .o_direction   (o_direction)
    );

endmodule

// File: rtl/core/pac_checker.sv
// Port-level assertions for the axis PID controller, bound to the top level.
`include "assert_macros.svh"

module pac_checker #(
    parameter bit INVERT_DIRECTION = pac_pkg::INVERT_DIRECTION_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_stall,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic [15:0] i_pulse_count,
    input logic        i_direction
);

    `ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid && !i_in_stall, "pipeline not empty after reset")
    `ASSERT_CLK(a_stalled_result_holds, i_clk, i_rst_n, i_out_valid && i_out_stall |=> i_out_valid && $stable(i_pulse_count) && $stable(i_direction), "stalled result changed")
    `ASSERT_CLK(a_zero_pulse_direction, i_clk, i_rst_n, i_out_valid && (i_pulse_count == 16'd0) |-> i_direction == INVERT_DIRECTION, "zero output with reversed direction")

endmodule

bind pid_axis_controller_antiwindup pac_checker #(
    .INVERT_DIRECTION (INVERT_DIRECTION)
) u_pac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_stall    (o_stall),
    .i_out_valid   (o_valid),
    .i_out_stall   (i_stall),
    .i_pulse_count (o_pulse_count),
    .i_direction   (o_direction)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for the single-axis PID controller with anti-windup.
`timescale 1ns / 1ps

module testbench;
    import pac_pkg::*;

    localparam bit FLIP_DIR        = INVERT_DIRECTION_DEF;
    localparam int PIPE_LATENCY    = 3;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SQUEEZE_CYCLES  = 300;
    localparam int RANDOM_PHASES   = 12;
    localparam int REQS_PER_PHASE  = 75;
    localparam int SQUEEZE_PHASE   = 3;

    typedef struct packed {
        logic [9:0] position;
        logic       restart;
    } req_t;

    typedef struct packed {
        logic [15:0] count;
        logic        dir;
    } pulse_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [9:0]            i_position = '0;
    logic                  i_restart = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [15:0]           o_pulse_count;
    logic                  o_direction;

    pid_axis_controller_antiwindup #(
        .INVERT_DIRECTION(FLIP_DIR)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_position   (i_position),
        .i_restart    (i_restart),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pulse_count(o_pulse_count),
        .o_direction  (o_direction)
    );

    // controller mirror
    t_cfg   cfg_shadow;
    longint err_acc  = 0;
    longint prev_err = 0;

    req_t   pend_q[$];
    pulse_t pulse_q[$];

    int  n_queued     = 0;
    int  n_done       = 0;
    int  fails        = 0;
    int  quiet_cycles = 0;
    int  clamp_hits   = 0;
    int  restarts     = 0;
    int  n_settings   = 0;
    bit  in_taken     = 1'b0;
    bit  tx_idle_on   = 1'b0;
    bit  rx_idle_on   = 1'b0;
    bit  squeeze      = 1'b0;
    bit  squeeze_done = 1'b0;
    int  tx_gap       = 0;
    int  rx_gap       = 0;
    int  hold_left    = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // floor of gain * v / 2^16
    function automatic longint q16_mul(longint gain, longint v);
        return (gain * v) >>> 16;
    endfunction

    function automatic pulse_t predict_pulse(logic [9:0] pos, logic clr);
        pulse_t r;
        longint sp, px, err, prev, acc, p, ip, dp, total, lim, olim;
        sp   = cfg_shadow.setpoint;
        px   = pos;
        lim  = cfg_shadow.integral_limit;
        olim = cfg_shadow.output_limit;
        acc  = err_acc;
        if (clr) begin
            acc = 0;
            prev_err = 0;
            restarts++;
        end
        prev = prev_err;
        err = sp - px;
        if (mag_of(err) < longint'(cfg_shadow.error_deadzone))
            err = 0;
        p = q16_mul(cfg_shadow.gain_p, err);
        if ((err > 0 && prev < 0) || (err < 0 && prev > 0)) begin
            acc = 0;
        end else if (mag_of(p) < olim) begin
            acc += err;
            if (acc > lim)
                acc = lim;
            else if (acc < -lim)
                acc = -lim;
        end
        ip = q16_mul(cfg_shadow.gain_i, acc);
        dp = q16_mul(cfg_shadow.gain_d, err - prev);
        prev_err = err;
        total = p + ip + dp;
        if (total > olim) begin
            total = olim;
            clamp_hits++;
            if (acc > 0 && err > 0)
                acc -= err;
        end else if (total < -olim) begin
            total = -olim;
            clamp_hits++;
            if (acc < 0 && err < 0)
                acc -= err;
        end
        err_acc = acc;
        if (mag_of(total) < longint'(cfg_shadow.min_pulses))
            total = 0;
        r.dir   = (total < 0) ^ FLIP_DIR;
        r.count = 16'(mag_of(total));
        return r;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        req_t nxt;
        if (i_rst_n && !(i_valid && !in_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (tx_idle_on && $urandom_range(0, 5) == 0) begin
                tx_gap = $urandom_range(1, 17) - 1;
                i_valid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                nxt = pend_q.pop_front();
                i_valid    <= 1'b1;
                i_position <= nxt.position;
                i_restart  <= nxt.restart;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin
        logic hold;
        hold = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            hold = 1'b1;
        end else if (squeeze && !squeeze_done) begin
            squeeze_done = 1'b1;
            hold_left = SQUEEZE_CYCLES - 1;
            hold = 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            hold = 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(1, 17) - 1;
            hold = 1'b1;
        end
        i_stall <= hold;
    end

    // result checker and request predictor
    always @(posedge i_clk) begin
        pulse_t exp_r;
        logic   moved;
        if (!i_rst_n) begin
            in_taken     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            moved = (o_valid && !i_stall) || (i_valid && !o_stall);
            if (o_valid && !i_stall) begin
                if (pulse_q.size() == 0) begin
                    $error("unexpected result: pulse_count=%0d direction=%0d",
                           o_pulse_count, o_direction);
                    fails++;
                end else begin
                    exp_r = pulse_q.pop_front();
                    n_done <= n_done + 1;
                    if (o_pulse_count !== exp_r.count) begin
                        $error("pulse_count: expected %0d, got %0d", exp_r.count, o_pulse_count);
                        fails++;
                    end
                    if (o_direction !== exp_r.dir) begin
                        $error("direction: expected %0d, got %0d", exp_r.dir, o_direction);
                        fails++;
                    end
                end
            end
            if (i_valid && !o_stall)
                pulse_q.push_back(predict_pulse(i_position, i_restart));
            in_taken     <= i_valid && !o_stall;
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < WATCHDOG_LIMIT);
        $display("timeout after %0d idle cycles, %0d of %0d results seen",
                 quiet_cycles, n_done, n_queued);
        $display("pid_axis_controller_antiwindup: mismatch");
        $finish;
    end

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_SETPOINT:       cfg_shadow.setpoint       = val[9:0];
            REG_GAIN_P:         cfg_shadow.gain_p         = val[23:0];
            REG_GAIN_I:         cfg_shadow.gain_i         = val[23:0];
            REG_GAIN_D:         cfg_shadow.gain_d         = val[23:0];
            REG_INTEGRAL_LIMIT: cfg_shadow.integral_limit = val[19:0];
            REG_OUTPUT_LIMIT:   cfg_shadow.output_limit   = val[15:0];
            REG_ERROR_DEADZONE: cfg_shadow.error_deadzone = val[9:0];
            REG_MIN_PULSES:     cfg_shadow.min_pulses     = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_req(int pos, bit clr);
        req_t r;
        r.position = pos[9:0];
        r.restart  = clr;
        pend_q.push_back(r);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_done != n_queued) @(negedge i_clk);
        repeat (PIPE_LATENCY + 1) @(negedge i_clk);
    endtask

    function automatic int unsigned pick_val(int unsigned maxv, int unsigned typ);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return maxv;
            2, 3:    return $urandom_range(0, maxv);
            default: return $urandom_range(0, typ);
        endcase
    endfunction

    task automatic set_all(int unsigned sp, int unsigned gp, int unsigned gi, int unsigned gd,
                           int unsigned il, int unsigned ol, int unsigned dz, int unsigned mp);
        cfg_write(REG_SETPOINT, CFG_DATA_W'(sp));
        cfg_write(REG_GAIN_P, CFG_DATA_W'(gp));
        cfg_write(REG_GAIN_I, CFG_DATA_W'(gi));
        cfg_write(REG_GAIN_D, CFG_DATA_W'(gd));
        cfg_write(REG_INTEGRAL_LIMIT, CFG_DATA_W'(il));
        cfg_write(REG_OUTPUT_LIMIT, CFG_DATA_W'(ol));
        cfg_write(REG_ERROR_DEADZONE, CFG_DATA_W'(dz));
        cfg_write(REG_MIN_PULSES, CFG_DATA_W'(mp));
        n_settings++;
        @(posedge i_clk);
    endtask

    initial begin
        int pos;
        cfg_shadow = '{setpoint: RST_SETPOINT, gain_p: RST_GAIN_P, gain_i: RST_GAIN_I,
                       gain_d: RST_GAIN_D, integral_limit: RST_INTEGRAL_LIMIT,
                       output_limit: RST_OUTPUT_LIMIT, error_deadzone: RST_ERROR_DEADZONE,
                       min_pulses: RST_MIN_PULSES};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: deadzone edges, sign flips, restart
        n_settings++;
        queue_req(160, 0); queue_req(162, 0); queue_req(163, 0); queue_req(157, 0);
        queue_req(0, 0);   queue_req(1023, 0); queue_req(1023, 1); queue_req(0, 0);
        wait_drained();

        // full-scale gains: saturation and back-calculation
        set_all(1023, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 16'hFFFF, 0, 0);
        queue_req(0, 0); queue_req(0, 0); queue_req(1023, 0);
        queue_req(1022, 0); queue_req(0, 1); queue_req(1023, 0);
        wait_drained();

        // zero limits, widest deadzone, largest minimum
        set_all(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 1023, 16'hFFFF);
        queue_req(1023, 0); queue_req(1023, 0); queue_req(0, 0); queue_req(512, 0);
        wait_drained();

        // small outputs suppressed by the minimum pulse count
        set_all(512, 24'h000100, 0, 0, 20'hFFFFF, 16'hFFFF, 0, 4);
        queue_req(1023, 0); queue_req(511, 0); queue_req(0, 0); queue_req(513, 1);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_all(pick_val(1023, 1023), pick_val(24'hFFFFFF, 262144),
                    pick_val(24'hFFFFFF, 262144), pick_val(24'hFFFFFF, 262144),
                    pick_val(20'hFFFFF, 5000), pick_val(16'hFFFF, 3000),
                    pick_val(1023, 8), pick_val(16'hFFFF, 20));
            tx_idle_on = (ph < RANDOM_PHASES - 2) && $urandom_range(0, 2) != 0;
            rx_idle_on = (ph < RANDOM_PHASES - 2) && $urandom_range(0, 2) != 0;
            for (int k = 0; k < REQS_PER_PHASE; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: pos = int'(cfg_shadow.setpoint) + $urandom_range(0, 64) - 32;
                    6:                pos = cfg_shadow.setpoint;
                    7, 8:             pos = $urandom_range(0, 1023);
                    default:          pos = $urandom_range(0, 1) ? 1023 : 0;
                endcase
                if (pos < 0)
                    pos = 0;
                else if (pos > 1023)
                    pos = 1023;
                queue_req(pos, $urandom_range(0, 19) == 0);
            end
            if (ph == SQUEEZE_PHASE)
                squeeze = 1'b1;
            wait_drained();
        end

        repeat (2 * PIPE_LATENCY + 4) @(posedge i_clk);
        if (pulse_q.size() != 0) begin
            $error("%0d expected results never arrived", pulse_q.size());
            fails++;
        end
        $display("covered %0d requests over %0d register settings, incl. a %0d-cycle output hold",
                 n_queued, n_settings, SQUEEZE_CYCLES);
        $display("%0d outputs hit the clamp, %0d requests restarted the loop",
                 clamp_hits, restarts);
        if (fails == 0)
            $display("pid_axis_controller_antiwindup: match");
        else
            $display("pid_axis_controller_antiwindup: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pac_pkg.sv
rtl/core/pac_front.sv
rtl/core/pac_back.sv
rtl/core/pid_axis_controller_antiwindup.sv
rtl/core/pac_checker.sv
tb/sv/testbench.sv
